### src/tlbms_pkg.sv
package tlbms_pkg;

    // light table geometry
    localparam int LIGHT_RES_DEFAULT = 256;
    localparam int TABLE_AW          = 16;
    localparam int TABLE_DEPTH       = 1 << TABLE_AW;

    // field widths
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PROD_W     = 2 * CHAN_W;
    localparam int OFS_W      = 9;
    localparam int ZOOM_W     = 9;
    localparam int PIX_W      = 10;
    localparam int SCALED_W   = PIX_W + ZOOM_W;
    localparam int COORD_S_W  = 13;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 24;

    // configuration port
    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 32;
    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 9'd192;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_SHADE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        REG_LIGHT_ONE_X = 3'd0,
        REG_LIGHT_ONE_Y = 3'd1,
        REG_LIGHT_TWO_X = 3'd2,
        REG_LIGHT_TWO_Y = 3'd3,
        REG_ZOOM        = 3'd4
    } reg_idx_t;

    // light table write port
    typedef struct packed {
        logic                en;
        logic [TABLE_AW-1:0] addr;
        logic [CHAN_W-1:0]   data;
    } tbl_wr_t;

    // floor(p / 255) for p up to 255 * 255
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] sum;
        sum = {1'b0, p} + {{(CHAN_W + 1){1'b0}}, p[PROD_W-1:CHAN_W]} + 1'b1;
        return sum[PROD_W-1:CHAN_W];
    endfunction

endpackage

### src/two_light_bump_map_shader_unit.sv
// two-light bump map shader
// input stream (s_axis_*): one command per transaction. tuser selects the
// command: load writes table_value into the light table at table_addr and
// gives no result; shade lights one pixel and gives exactly one result.
// output stream (m_axis_*): one shaded rgb pixel per shade command, in order.
// apb port: light offsets and zoom, written while the stream is quiet.
// seven register stages: coordinate scaling, slope offset, light offsets,
// table index, table read, light sum and channel multiply, final scaling
// into the output register. throughput: one command per cycle while the
// output is not stalled; the two light lookups use the two read ports of
// the table memory in the same cycle, so nothing is shared.
// a load is visible to every shade command accepted after it.
// reset clears all stage valid bits and the configuration registers (zoom to
// 192); the light table is not cleared and reads garbage until loaded.
// when the receiver stalls, the whole pipeline holds and s_axis_tready drops
// only while the output register is full and not being taken.
module two_light_bump_map_shader_unit #(
    parameter int LIGHT_RES = tlbms_pkg::LIGHT_RES_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tlbms_pkg::CFG_AW-1:0]         paddr,
    input  logic [tlbms_pkg::CFG_DW-1:0]         pwdata,
    output logic [tlbms_pkg::CFG_DW-1:0]         prdata,
    output logic                                 pready,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // table_addr, table_value, pixel_x, pixel_y, left_rgb, centre_red,
    // upper_red, bump_rgb, zero fill
    input  logic [tlbms_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // command
    input  logic                                 s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_red, out_green, out_blue
    output logic [tlbms_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int CW     = tlbms_pkg::CHAN_W;
    localparam int NCH    = tlbms_pkg::NUM_CHAN;
    localparam int PW     = tlbms_pkg::PROD_W;
    localparam int SW     = tlbms_pkg::COORD_S_W;
    localparam int AW     = tlbms_pkg::TABLE_AW;
    localparam int COORD_W = $clog2(LIGHT_RES);
    localparam int IDX_W  = (2 * COORD_W > AW) ? 2 * COORD_W : AW;
    localparam logic signed [SW-1:0] RES_S = SW'(LIGHT_RES);
    localparam logic [IDX_W-1:0]     RES_I = IDX_W'(LIGHT_RES);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [tlbms_pkg::OFS_W-1:0] l1x_reg, l1y_reg, l2x_reg, l2y_reg;
    logic [tlbms_pkg::ZOOM_W-1:0]       zoom_reg;
    logic                               cfg_wr;
    tlbms_pkg::reg_idx_t                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = tlbms_pkg::reg_idx_t'(paddr[tlbms_pkg::CFG_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1x_reg  <= '0;
            l1y_reg  <= '0;
            l2x_reg  <= '0;
            l2y_reg  <= '0;
            zoom_reg <= tlbms_pkg::ZOOM_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                tlbms_pkg::REG_LIGHT_ONE_X: l1x_reg  <= pwdata[tlbms_pkg::OFS_W-1:0];
                tlbms_pkg::REG_LIGHT_ONE_Y: l1y_reg  <= pwdata[tlbms_pkg::OFS_W-1:0];
                tlbms_pkg::REG_LIGHT_TWO_X: l2x_reg  <= pwdata[tlbms_pkg::OFS_W-1:0];
                tlbms_pkg::REG_LIGHT_TWO_Y: l2y_reg  <= pwdata[tlbms_pkg::OFS_W-1:0];
                tlbms_pkg::REG_ZOOM:        zoom_reg <= pwdata[tlbms_pkg::ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_idx)
            tlbms_pkg::REG_LIGHT_ONE_X:
                prdata = {{(tlbms_pkg::CFG_DW - tlbms_pkg::OFS_W){1'b0}}, l1x_reg};
            tlbms_pkg::REG_LIGHT_ONE_Y:
                prdata = {{(tlbms_pkg::CFG_DW - tlbms_pkg::OFS_W){1'b0}}, l1y_reg};
            tlbms_pkg::REG_LIGHT_TWO_X:
                prdata = {{(tlbms_pkg::CFG_DW - tlbms_pkg::OFS_W){1'b0}}, l2x_reg};
            tlbms_pkg::REG_LIGHT_TWO_Y:
                prdata = {{(tlbms_pkg::CFG_DW - tlbms_pkg::OFS_W){1'b0}}, l2y_reg};
            tlbms_pkg::REG_ZOOM:
                prdata = {{(tlbms_pkg::CFG_DW - tlbms_pkg::ZOOM_W){1'b0}}, zoom_reg};
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together
    // ------------------------------------------------------------------
    logic advance;
    logic m_valid_reg;

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // input field unpacking
    logic [AW-1:0]                   in_taddr;
    logic [CW-1:0]                   in_tval;
    logic [tlbms_pkg::PIX_W-1:0]     in_px, in_py;
    logic [NCH*CW-1:0]               in_left, in_bump;
    logic [CW-1:0]                   in_centre, in_upper;

    assign in_taddr  = s_axis_tdata[15:0];
    assign in_tval   = s_axis_tdata[23:16];
    assign in_px     = s_axis_tdata[33:24];
    assign in_py     = s_axis_tdata[43:34];
    assign in_left   = s_axis_tdata[67:44];
    assign in_centre = s_axis_tdata[75:68];
    assign in_upper  = s_axis_tdata[83:76];
    assign in_bump   = s_axis_tdata[107:84];

    // ------------------------------------------------------------------
    // stage 1: scale coordinates, colour products
    // ------------------------------------------------------------------
    logic                               v1_reg;
    tlbms_pkg::cmd_t                    cmd1_reg;
    logic [AW-1:0]                      taddr1_reg;
    logic [CW-1:0]                      tval1_reg;
    logic [tlbms_pkg::SCALED_W-1:0]     xs1_reg, ys1_reg;
    logic [CW-1:0]                      lr1_reg, centre1_reg, upper1_reg;
    logic [NCH-1:0][PW-1:0]             cprod1_reg;
    logic                               black1_reg;
    logic [NCH-1:0][PW-1:0]             cprod1_next;

    // channel 0 is red, taken from the high byte
    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            cprod1_next[i] = PW'(in_left[(NCH-1-i)*CW +: CW]) *
                             PW'(in_bump[(NCH-1-i)*CW +: CW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd1_reg    <= tlbms_pkg::cmd_t'(s_axis_tuser);
            taddr1_reg  <= in_taddr;
            tval1_reg   <= in_tval;
            xs1_reg     <= tlbms_pkg::SCALED_W'(in_px) * tlbms_pkg::SCALED_W'(zoom_reg);
            ys1_reg     <= tlbms_pkg::SCALED_W'(in_py) * tlbms_pkg::SCALED_W'(zoom_reg);
            lr1_reg     <= in_left[NCH*CW-1 -: CW];
            centre1_reg <= in_centre;
            upper1_reg  <= in_upper;
            cprod1_reg  <= cprod1_next;
            black1_reg  <= (in_px == '0) || (in_py == '0);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: slope offset, first scaling of colour products
    // ------------------------------------------------------------------
    logic                               v2_reg;
    tlbms_pkg::cmd_t                    cmd2_reg;
    logic [AW-1:0]                      taddr2_reg;
    logic [CW-1:0]                      tval2_reg;
    logic signed [SW-1:0]               px2_reg, py2_reg;
    logic [NCH-1:0][CW-1:0]             q2_reg;
    logic                               black2_reg;
    logic signed [SW-1:0]               px2_next, py2_next;
    logic [NCH-1:0][CW-1:0]             q2_next;

    always_comb
    begin
        px2_next = SW'(xs1_reg[tlbms_pkg::SCALED_W-1:8]) + SW'(lr1_reg) - SW'(centre1_reg);
        py2_next = SW'(ys1_reg[tlbms_pkg::SCALED_W-1:8]) + SW'(upper1_reg)
                 - SW'(centre1_reg);
        for (int i = 0; i < NCH; i++)
        begin
            q2_next[i] = tlbms_pkg::div255(cprod1_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd2_reg   <= cmd1_reg;
            taddr2_reg <= taddr1_reg;
            tval2_reg  <= tval1_reg;
            px2_reg    <= px2_next;
            py2_reg    <= py2_next;
            q2_reg     <= q2_next;
            black2_reg <= black1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: light positions and bounds
    // ------------------------------------------------------------------
    logic                               v3_reg;
    tlbms_pkg::cmd_t                    cmd3_reg;
    logic [AW-1:0]                      taddr3_reg;
    logic [CW-1:0]                      tval3_reg;
    logic [COORD_W-1:0]                 x1_3_reg, y1_3_reg, x2_3_reg, y2_3_reg;
    logic                               ok1_3_reg, ok2_3_reg;
    logic [NCH-1:0][CW-1:0]             q3_reg;
    logic                               black3_reg;
    logic signed [SW-1:0]               lx1, ly1, lx2, ly2;

    assign lx1 = px2_reg + SW'(l1x_reg);
    assign ly1 = py2_reg + SW'(l1y_reg);
    assign lx2 = px2_reg + SW'(l2x_reg);
    assign ly2 = py2_reg + SW'(l2y_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd3_reg   <= cmd2_reg;
            taddr3_reg <= taddr2_reg;
            tval3_reg  <= tval2_reg;
            x1_3_reg   <= lx1[COORD_W-1:0];
            y1_3_reg   <= ly1[COORD_W-1:0];
            x2_3_reg   <= lx2[COORD_W-1:0];
            y2_3_reg   <= ly2[COORD_W-1:0];
            ok1_3_reg  <= (lx1 >= 0) && (lx1 < RES_S) && (ly1 >= 0) && (ly1 < RES_S);
            ok2_3_reg  <= (lx2 >= 0) && (lx2 < RES_S) && (ly2 >= 0) && (ly2 < RES_S);
            q3_reg     <= q2_reg;
            black3_reg <= black2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: table index (load address for a load command)
    // ------------------------------------------------------------------
    logic                               v4_reg;
    tlbms_pkg::cmd_t                    cmd4_reg;
    logic [AW-1:0]                      addr1_4_reg, addr2_4_reg;
    logic [CW-1:0]                      tval4_reg;
    logic                               ok1_4_reg, ok2_4_reg;
    logic [NCH-1:0][CW-1:0]             q4_reg;
    logic                               black4_reg;
    logic [IDX_W-1:0]                   idx1, idx2;
    logic [AW-1:0]                      addr1_4_next;

    assign idx1 = IDX_W'(y1_3_reg) * RES_I + IDX_W'(x1_3_reg);
    assign idx2 = IDX_W'(y2_3_reg) * RES_I + IDX_W'(x2_3_reg);
    assign addr1_4_next = (cmd3_reg == tlbms_pkg::CMD_LOAD) ? taddr3_reg : idx1[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd4_reg    <= cmd3_reg;
            addr1_4_reg <= addr1_4_next;
            addr2_4_reg <= idx2[AW-1:0];
            tval4_reg   <= tval3_reg;
            ok1_4_reg   <= ok1_3_reg;
            ok2_4_reg   <= ok2_3_reg;
            q4_reg      <= q3_reg;
            black4_reg  <= black3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: light table access
    // ------------------------------------------------------------------
    tlbms_pkg::tbl_wr_t                 tbl_wr;
    logic [CW-1:0]                      rd1, rd2;
    logic                               v5_reg;
    tlbms_pkg::cmd_t                    cmd5_reg;
    logic                               ok1_5_reg, ok2_5_reg;
    logic [NCH-1:0][CW-1:0]             q5_reg;
    logic                               black5_reg;

    assign tbl_wr.en   = advance && v4_reg && (cmd4_reg == tlbms_pkg::CMD_LOAD);
    assign tbl_wr.addr = addr1_4_reg;
    assign tbl_wr.data = tval4_reg;

    tlbms_light_ram u_light_ram (
        .clk       (clk),
        .wr        (tbl_wr),
        .rd_en     (advance),
        .rd_addr_a (addr1_4_reg),
        .rd_addr_b (addr2_4_reg),
        .rd_data_a (rd1),
        .rd_data_b (rd2)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd5_reg   <= cmd4_reg;
            ok1_5_reg  <= ok1_4_reg;
            ok2_5_reg  <= ok2_4_reg;
            q5_reg     <= q4_reg;
            black5_reg <= black4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: saturated light sum, intensity multiply
    // ------------------------------------------------------------------
    logic                               v6_reg;
    tlbms_pkg::cmd_t                    cmd6_reg;
    logic [NCH-1:0][PW-1:0]             prod6_reg;
    logic                               black6_reg;
    logic [CW:0]                        lsum;
    logic [CW-1:0]                      lsat;
    logic [NCH-1:0][PW-1:0]             prod6_next;

    always_comb
    begin
        lsum = (ok1_5_reg ? {1'b0, rd1} : '0) + (ok2_5_reg ? {1'b0, rd2} : '0);
        lsat = lsum[CW] ? {CW{1'b1}} : lsum[CW-1:0];
        for (int i = 0; i < NCH; i++)
        begin
            prod6_next[i] = PW'(q5_reg[i]) * PW'(lsat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd6_reg   <= cmd5_reg;
            prod6_reg  <= prod6_next;
            black6_reg <= black5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: final scaling into the output register
    // ------------------------------------------------------------------
    logic [tlbms_pkg::OUT_DATA_W-1:0]   m_data_reg;
    logic [tlbms_pkg::OUT_DATA_W-1:0]   m_data_next;

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            m_data_next[i*CW +: CW] = black6_reg ? '0 : tlbms_pkg::div255(prod6_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_data_reg <= m_data_next;
        end
    end

    // stage valid bits; a load leaves the pipeline without a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg      <= s_axis_tvalid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            m_valid_reg <= v6_reg && (cmd6_reg == tlbms_pkg::CMD_SHADE);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a stall freezes every stage valid bit
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, m_valid_reg}))
        else $error("pipeline moved during a stall");

    // an edge pixel comes out black
    a_edge_black: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && v6_reg && (cmd6_reg == tlbms_pkg::CMD_SHADE) && black6_reg)
        |=> (m_axis_tdata == '0))
        else $error("edge pixel not black");

    // a result only ever comes from a shade command
    a_result_from_shade: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid)
        |-> $past(advance && v6_reg && (cmd6_reg == tlbms_pkg::CMD_SHADE)))
        else $error("result without a shade command");

endmodule

### src/tlbms_light_ram.sv
module tlbms_light_ram (
    input  logic                               clk,
    input  tlbms_pkg::tbl_wr_t                 wr,
    input  logic                               rd_en,
    input  logic [tlbms_pkg::TABLE_AW-1:0]     rd_addr_a,
    input  logic [tlbms_pkg::TABLE_AW-1:0]     rd_addr_b,
    output logic [tlbms_pkg::CHAN_W-1:0]       rd_data_a,
    output logic [tlbms_pkg::CHAN_W-1:0]       rd_data_b
);

    logic [tlbms_pkg::CHAN_W-1:0] mem [tlbms_pkg::TABLE_DEPTH];
    logic [tlbms_pkg::CHAN_W-1:0] rd_data_a_reg;
    logic [tlbms_pkg::CHAN_W-1:0] rd_data_b_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // two registered read ports, held while the pipeline stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule
